// ===== sv/brfrc_pkg.sv =====
// ----------------------------------------------------------------------------
// brfrc_pkg: shared definitions for the byte ring FIFO with reserve/commit
// Command and status codes, sequencer states, the shared unit's operations
// and the control/flag bundles passed between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package brfrc_pkg;

  // Default sizes for the top-level parameters.
  localparam int unsigned DepthDef   = 1024;
  localparam int unsigned MaxReadDef = 64;

  // Field widths fixed by the interface.
  localparam int unsigned CmdW    = 3;
  localparam int unsigned LenW    = 10;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 3;

  // Command codes.
  localparam logic [CmdW-1:0] CMD_RESERVE = 3'd0;
  localparam logic [CmdW-1:0] CMD_PUT     = 3'd1;
  localparam logic [CmdW-1:0] CMD_COMMIT  = 3'd2;
  localparam logic [CmdW-1:0] CMD_READ    = 3'd3;
  localparam logic [CmdW-1:0] CMD_ADVANCE = 3'd4;
  localparam logic [CmdW-1:0] CMD_CLOSE   = 3'd5;

  // Status codes.
  localparam logic [StatusW-1:0] STAT_OK       = 3'd0;
  localparam logic [StatusW-1:0] STAT_CLOSED   = 3'd1;
  localparam logic [StatusW-1:0] STAT_BLOCK    = 3'd2;
  localparam logic [StatusW-1:0] STAT_PENDING  = 3'd3;
  localparam logic [StatusW-1:0] STAT_MISMATCH = 3'd4;
  localparam logic [StatusW-1:0] STAT_TOO_LONG = 3'd5;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_GAPFIX,
    S_CHECK,
    S_MODRED,
    S_RDADDR,
    S_RDEMIT
  } state_e;

  // Operations of the shared add/subtract unit.
  typedef enum logic [2:0] {
    ALU_NONE,
    ALU_GAP_RES,  // read pointer minus write pointer
    ALU_GAP_RD,   // write pointer minus read pointer
    ALU_FIX,      // accumulator plus DEPTH
    ALU_FREE,     // length minus (accumulator, or DEPTH when zero)
    ALU_AVAIL,    // accumulator minus length
    ALU_ADV,      // read pointer plus length
    ALU_MOD       // accumulator minus DEPTH
  } alu_op_e;

  // Source of the count field of a result beat.
  typedef enum logic [1:0] {
    CNT_ZERO,
    CNT_ONE,
    CNT_LEN
  } cnt_sel_e;

  // Flags from the datapath to the sequencer.
  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic            in_valid;
    logic            closed;
    logic            popen;
    logic            prem_zero;
    logic            too_long;
    logic            len_zero;
    logic            acc_neg;
    logic            alu_neg;
    logic            slot_free;
    logic            rd_last;
  } flags_t;

  // Strobes from the sequencer to the datapath.
  typedef struct packed {
    logic               in_ready;
    alu_op_e            alu_op;
    logic               acc_ld;
    logic               emit;
    logic [StatusW-1:0] res_status;
    cnt_sel_e           res_cnt;
    logic               res_byte;
    logic               put_do;
    logic               commit_do;
    logic               reserve_do;
    logic               close_do;
    logic               rp_load;
    logic               rp_inc;
    logic               idx_clr;
    logic               mem_rd;
  } ctl_t;

endpackage

// ===== sv/brfrc_mem.sv =====
// ----------------------------------------------------------------------------
// brfrc_mem: byte store of the ring
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module brfrc_mem #(
  parameter int unsigned DEPTH = brfrc_pkg::DepthDef
) (
  input  logic                         clk_i,
  input  logic                         wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]     wr_addr_i,
  input  logic [brfrc_pkg::ByteW-1:0]  wr_data_i,
  input  logic                         rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]     rd_addr_i,
  output logic [brfrc_pkg::ByteW-1:0]  rd_data_o
);

  logic [brfrc_pkg::ByteW-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

// ===== sv/brfrc_alu.sv =====
// ----------------------------------------------------------------------------
// brfrc_alu: shared add/subtract unit
// Selects its operands by operation and forms one signed sum; the sequencer
// reuses it for ring distances, space checks and pointer wrap reduction.
// ----------------------------------------------------------------------------
module brfrc_alu #(
  parameter int unsigned DEPTH = brfrc_pkg::DepthDef,
  localparam int unsigned PtrW = $clog2(DEPTH),
  localparam int unsigned MagW = (PtrW + 1 > 11) ? PtrW + 1 : 11,
  localparam int unsigned AccW = MagW + 1
) (
  input  brfrc_pkg::alu_op_e           op_i,
  input  logic [PtrW-1:0]              rp_i,
  input  logic [PtrW-1:0]              wp_i,
  input  logic [AccW-1:0]              acc_i,
  input  logic [brfrc_pkg::LenW-1:0]   len_i,
  output logic [AccW-1:0]              res_o,
  output logic                         neg_o
);

  localparam logic [AccW-1:0] DepthVal = AccW'(DEPTH);

  logic [AccW-1:0] a;
  logic [AccW-1:0] b;
  logic            sub;
  logic [AccW-1:0] rp_ext;
  logic [AccW-1:0] wp_ext;
  logic [AccW-1:0] len_ext;

  assign rp_ext  = {{(AccW - PtrW){1'b0}}, rp_i};
  assign wp_ext  = {{(AccW - PtrW){1'b0}}, wp_i};
  assign len_ext = {{(AccW - brfrc_pkg::LenW){1'b0}}, len_i};

  // Operand selection.
  always_comb begin
    a   = '0;
    b   = '0;
    sub = 1'b0;
    case (op_i)
      brfrc_pkg::ALU_GAP_RES: begin
        a   = rp_ext;
        b   = wp_ext;
        sub = 1'b1;
      end
      brfrc_pkg::ALU_GAP_RD: begin
        a   = wp_ext;
        b   = rp_ext;
        sub = 1'b1;
      end
      brfrc_pkg::ALU_FIX: begin
        a = acc_i;
        b = DepthVal;
      end
      brfrc_pkg::ALU_FREE: begin
        // An empty ring (distance zero) counts as a full DEPTH of distance.
        a   = len_ext;
        b   = (acc_i == '0) ? DepthVal : acc_i;
        sub = 1'b1;
      end
      brfrc_pkg::ALU_AVAIL: begin
        a   = acc_i;
        b   = len_ext;
        sub = 1'b1;
      end
      brfrc_pkg::ALU_ADV: begin
        a = rp_ext;
        b = len_ext;
      end
      brfrc_pkg::ALU_MOD: begin
        a   = acc_i;
        b   = DepthVal;
        sub = 1'b1;
      end
      default: begin
        a   = '0;
        b   = '0;
        sub = 1'b0;
      end
    endcase
  end

  // The single adder.
  assign res_o = a + (sub ? ~b : b) + {{(AccW - 1){1'b0}}, sub};
  assign neg_o = res_o[AccW-1];

endmodule

// ===== sv/brfrc_ctrl.sv =====
// ----------------------------------------------------------------------------
// brfrc_ctrl: command sequencer
// Steps each command through decode, the shared unit's passes and the
// result beats, and drives the datapath strobes.
// ----------------------------------------------------------------------------
module brfrc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  brfrc_pkg::flags_t   flags_i,
  output brfrc_pkg::ctl_t     ctl_o
);

  brfrc_pkg::state_e state_q;
  brfrc_pkg::state_e state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= brfrc_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      brfrc_pkg::S_IDLE: begin
        if (flags_i.in_valid) begin
          state_d = brfrc_pkg::S_DECODE;
        end
      end
      brfrc_pkg::S_DECODE: begin
        case (flags_i.cmd)
          brfrc_pkg::CMD_RESERVE: begin
            if (flags_i.closed || flags_i.popen) begin
              if (flags_i.slot_free) begin
                state_d = brfrc_pkg::S_IDLE;
              end
            end else begin
              state_d = brfrc_pkg::S_GAPFIX;
            end
          end
          brfrc_pkg::CMD_READ: begin
            if (flags_i.too_long) begin
              if (flags_i.slot_free) begin
                state_d = brfrc_pkg::S_IDLE;
              end
            end else begin
              state_d = brfrc_pkg::S_GAPFIX;
            end
          end
          brfrc_pkg::CMD_ADVANCE: state_d = brfrc_pkg::S_MODRED;
          brfrc_pkg::CMD_PUT, brfrc_pkg::CMD_COMMIT, brfrc_pkg::CMD_CLOSE: begin
            if (flags_i.slot_free) begin
              state_d = brfrc_pkg::S_IDLE;
            end
          end
          default: state_d = brfrc_pkg::S_IDLE;
        endcase
      end
      brfrc_pkg::S_GAPFIX: state_d = brfrc_pkg::S_CHECK;
      brfrc_pkg::S_CHECK: begin
        if (flags_i.cmd == brfrc_pkg::CMD_READ && !flags_i.alu_neg &&
            !flags_i.len_zero) begin
          state_d = brfrc_pkg::S_RDADDR;
        end else if (flags_i.slot_free) begin
          state_d = brfrc_pkg::S_IDLE;
        end
      end
      brfrc_pkg::S_MODRED: begin
        if (flags_i.alu_neg && flags_i.slot_free) begin
          state_d = brfrc_pkg::S_IDLE;
        end
      end
      brfrc_pkg::S_RDADDR: state_d = brfrc_pkg::S_RDEMIT;
      brfrc_pkg::S_RDEMIT: begin
        if (flags_i.slot_free) begin
          state_d = flags_i.rd_last ? brfrc_pkg::S_IDLE : brfrc_pkg::S_RDADDR;
        end
      end
      default: state_d = brfrc_pkg::S_IDLE;
    endcase
  end

  // Datapath strobes.
  always_comb begin
    ctl_o            = '0;
    ctl_o.alu_op     = brfrc_pkg::ALU_NONE;
    ctl_o.res_status = brfrc_pkg::STAT_OK;
    ctl_o.res_cnt    = brfrc_pkg::CNT_ZERO;
    case (state_q)
      brfrc_pkg::S_IDLE: ctl_o.in_ready = 1'b1;
      brfrc_pkg::S_DECODE: begin
        case (flags_i.cmd)
          brfrc_pkg::CMD_RESERVE: begin
            if (flags_i.closed) begin
              ctl_o.emit       = flags_i.slot_free;
              ctl_o.res_status = brfrc_pkg::STAT_CLOSED;
            end else if (flags_i.popen) begin
              ctl_o.emit       = flags_i.slot_free;
              ctl_o.res_status = brfrc_pkg::STAT_PENDING;
            end else begin
              ctl_o.alu_op = brfrc_pkg::ALU_GAP_RES;
              ctl_o.acc_ld = 1'b1;
            end
          end
          brfrc_pkg::CMD_PUT: begin
            ctl_o.emit = flags_i.slot_free;
            if (flags_i.closed) begin
              ctl_o.res_status = brfrc_pkg::STAT_CLOSED;
            end else if (flags_i.prem_zero) begin
              ctl_o.res_status = brfrc_pkg::STAT_MISMATCH;
            end else begin
              ctl_o.res_cnt = brfrc_pkg::CNT_ONE;
              ctl_o.put_do  = flags_i.slot_free;
            end
          end
          brfrc_pkg::CMD_COMMIT: begin
            ctl_o.emit = flags_i.slot_free;
            if (flags_i.closed) begin
              ctl_o.res_status = brfrc_pkg::STAT_CLOSED;
            end else if (!flags_i.popen || !flags_i.prem_zero) begin
              ctl_o.res_status = brfrc_pkg::STAT_MISMATCH;
            end else begin
              ctl_o.commit_do = flags_i.slot_free;
            end
          end
          brfrc_pkg::CMD_READ: begin
            if (flags_i.too_long) begin
              ctl_o.emit       = flags_i.slot_free;
              ctl_o.res_status = brfrc_pkg::STAT_TOO_LONG;
            end else begin
              ctl_o.alu_op = brfrc_pkg::ALU_GAP_RD;
              ctl_o.acc_ld = 1'b1;
            end
          end
          brfrc_pkg::CMD_ADVANCE: begin
            ctl_o.alu_op = brfrc_pkg::ALU_ADV;
            ctl_o.acc_ld = 1'b1;
          end
          brfrc_pkg::CMD_CLOSE: begin
            ctl_o.emit     = flags_i.slot_free;
            ctl_o.close_do = flags_i.slot_free;
          end
          default: ctl_o.emit = 1'b0;
        endcase
      end
      brfrc_pkg::S_GAPFIX: begin
        // A negative distance wraps around the ring.
        ctl_o.alu_op = brfrc_pkg::ALU_FIX;
        ctl_o.acc_ld = flags_i.acc_neg;
      end
      brfrc_pkg::S_CHECK: begin
        if (flags_i.cmd == brfrc_pkg::CMD_READ) begin
          ctl_o.alu_op = brfrc_pkg::ALU_AVAIL;
          if (flags_i.alu_neg) begin
            ctl_o.emit       = flags_i.slot_free;
            ctl_o.res_status = flags_i.closed ? brfrc_pkg::STAT_CLOSED
                                              : brfrc_pkg::STAT_BLOCK;
          end else if (flags_i.len_zero) begin
            ctl_o.emit = flags_i.slot_free;
          end else begin
            ctl_o.idx_clr = 1'b1;
          end
        end else begin
          // Free space is below the length when the sum does not go negative.
          ctl_o.alu_op = brfrc_pkg::ALU_FREE;
          ctl_o.emit   = flags_i.slot_free;
          if (!flags_i.alu_neg) begin
            ctl_o.res_status = brfrc_pkg::STAT_BLOCK;
          end else begin
            ctl_o.res_cnt    = brfrc_pkg::CNT_LEN;
            ctl_o.reserve_do = flags_i.slot_free;
          end
        end
      end
      brfrc_pkg::S_MODRED: begin
        ctl_o.alu_op = brfrc_pkg::ALU_MOD;
        if (!flags_i.alu_neg) begin
          ctl_o.acc_ld = 1'b1;
        end else begin
          ctl_o.emit    = flags_i.slot_free;
          ctl_o.res_cnt = brfrc_pkg::CNT_LEN;
          ctl_o.rp_load = flags_i.slot_free;
        end
      end
      brfrc_pkg::S_RDADDR: ctl_o.mem_rd = 1'b1;
      brfrc_pkg::S_RDEMIT: begin
        ctl_o.emit     = flags_i.slot_free;
        ctl_o.res_cnt  = brfrc_pkg::CNT_LEN;
        ctl_o.res_byte = 1'b1;
        ctl_o.rp_inc   = flags_i.slot_free;
      end
      default: ctl_o.in_ready = 1'b0;
    endcase
  end

endmodule

// ===== sv/byte_ring_fifo_reserve_commit.sv =====
// ----------------------------------------------------------------------------
// byte_ring_fifo_reserve_commit: byte ring FIFO with reserve and commit
// A ring of DEPTH bytes holding at most DEPTH-1 of them. One command is
// taken at a time and answered with one result beat, or with one beat per
// byte for a read; the input side is ready only between commands. A command
// with an unused code gives no beat. Every byte of a read costs a registered
// read of the byte store and then a beat into the output register. Advance
// reduces the new read pointer by subtracting DEPTH in the shared adder, one
// subtraction per cycle, until it lies inside the ring; it wraps past DEPTH
// at most once when DEPTH is 1024 or more. A beat is formed only when the
// output register is empty or its beat is being taken.
// ----------------------------------------------------------------------------
module byte_ring_fifo_reserve_commit #(
  parameter int unsigned DEPTH    = brfrc_pkg::DepthDef,
  parameter int unsigned MAX_READ = brfrc_pkg::MaxReadDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [brfrc_pkg::CmdW-1:0]     cmd_i,
  input  logic [brfrc_pkg::LenW-1:0]     length_i,
  input  logic [brfrc_pkg::ByteW-1:0]    data_in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [brfrc_pkg::StatusW-1:0]  status_o,
  output logic [brfrc_pkg::LenW-1:0]     count_o,
  output logic [brfrc_pkg::ByteW-1:0]    data_out_o,
  output logic                           last_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned MagW = (PtrW + 1 > 11) ? PtrW + 1 : 11;
  localparam int unsigned AccW = MagW + 1;
  localparam int unsigned IdxW = $clog2(MAX_READ + 1);
  localparam int unsigned LenW = brfrc_pkg::LenW;
  localparam logic [PtrW-1:0] PtrMax = PtrW'(DEPTH - 1);

  brfrc_pkg::ctl_t   ctl;
  brfrc_pkg::flags_t flags;

  // Latched command.
  logic [brfrc_pkg::CmdW-1:0]  cmd_q;
  logic [LenW-1:0]             len_q;
  logic [brfrc_pkg::ByteW-1:0] din_q;

  // Ring state.
  logic [PtrW-1:0] rp_q;
  logic [PtrW-1:0] wp_q;
  logic [PtrW-1:0] pp_q;
  logic [LenW-1:0] prem_q;
  logic            popen_q;
  logic            closed_q;

  // Working registers.
  logic [AccW-1:0] acc_q;
  logic [IdxW-1:0] idx_q;

  // Output register.
  logic                          out_valid_q;
  logic [brfrc_pkg::StatusW-1:0] out_status_q;
  logic [LenW-1:0]               out_count_q;
  logic [brfrc_pkg::ByteW-1:0]   out_data_q;
  logic                          out_last_q;

  logic [AccW-1:0]             alu_res;
  logic                        alu_neg;
  logic [brfrc_pkg::ByteW-1:0] rd_data;
  logic                        accept;
  logic                        slot_free;
  logic                        rd_last;
  logic [PtrW-1:0]             rp_next;
  logic [PtrW-1:0]             pp_next;
  logic [LenW-1:0]             res_count;

  assign accept    = in_valid_i & in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;
  assign rd_last   = (LenW'(idx_q) + LenW'(1)) == len_q;
  assign rp_next   = (rp_q == PtrMax) ? '0 : rp_q + PtrW'(1);
  assign pp_next   = (pp_q == PtrMax) ? '0 : pp_q + PtrW'(1);

  // Flags for the sequencer.
  always_comb begin
    flags.cmd       = cmd_q;
    flags.in_valid  = in_valid_i;
    flags.closed    = closed_q;
    flags.popen     = popen_q;
    flags.prem_zero = (prem_q == '0);
    flags.too_long  = (len_q > LenW'(MAX_READ));
    flags.len_zero  = (len_q == '0);
    flags.acc_neg   = acc_q[AccW-1];
    flags.alu_neg   = alu_neg;
    flags.slot_free = slot_free;
    flags.rd_last   = rd_last;
  end

  brfrc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctl_o   (ctl)
  );

  brfrc_alu #(
    .DEPTH (DEPTH)
  ) u_alu (
    .op_i  (ctl.alu_op),
    .rp_i  (rp_q),
    .wp_i  (wp_q),
    .acc_i (acc_q),
    .len_i (len_q),
    .res_o (alu_res),
    .neg_o (alu_neg)
  );

  brfrc_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (ctl.put_do),
    .wr_addr_i (pp_q),
    .wr_data_i (din_q),
    .rd_en_i   (ctl.mem_rd),
    .rd_addr_i (rp_q),
    .rd_data_o (rd_data)
  );

  assign in_ready_o = ctl.in_ready;

  // Command capture and working registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
      len_q <= length_i;
      din_q <= data_in_i;
    end
    if (ctl.acc_ld) begin
      acc_q <= alu_res;
    end
  end

  // Read beat index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (ctl.idx_clr) begin
      idx_q <= '0;
    end else if (ctl.rp_inc) begin
      idx_q <= idx_q + IdxW'(1);
    end
  end

  // Ring pointers and reservation state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q     <= '0;
      wp_q     <= '0;
      pp_q     <= '0;
      prem_q   <= '0;
      popen_q  <= 1'b0;
      closed_q <= 1'b0;
    end else begin
      if (ctl.rp_load) begin
        rp_q <= acc_q[PtrW-1:0];
      end else if (ctl.rp_inc) begin
        rp_q <= rp_next;
      end
      if (ctl.reserve_do) begin
        pp_q    <= wp_q;
        prem_q  <= len_q;
        popen_q <= 1'b1;
      end else if (ctl.put_do) begin
        pp_q   <= pp_next;
        prem_q <= prem_q - LenW'(1);
      end else if (ctl.commit_do) begin
        wp_q    <= pp_q;
        popen_q <= 1'b0;
      end
      if (ctl.close_do) begin
        closed_q <= 1'b1;
      end
    end
  end

  // Count field of the beat being formed.
  always_comb begin
    case (ctl.res_cnt)
      brfrc_pkg::CNT_ONE: res_count = LenW'(1);
      brfrc_pkg::CNT_LEN: res_count = len_q;
      default:            res_count = '0;
    endcase
  end

  // Output register: valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register: payload.
  always_ff @(posedge clk_i) begin
    if (ctl.emit) begin
      out_status_q <= ctl.res_status;
      out_count_q  <= res_count;
      out_data_q   <= ctl.res_byte ? rd_data : '0;
      out_last_q   <= ctl.res_byte ? rd_last : 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign count_o     = out_count_q;
  assign data_out_o  = out_data_q;
  assign last_o      = out_last_q;

  // Bytes left to fill imply an open reservation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (prem_q != '0) |-> popen_q)
    else $error("pending bytes without an open reservation");

  // Each stored byte consumes exactly one reserved byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.put_do |=> (prem_q == $past(prem_q) - LenW'(1)))
    else $error("reserved count not decremented by a put");

  // Only read bytes leave a beat that is not the last of its command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_last_q) |-> (out_status_q == brfrc_pkg::STAT_OK))
    else $error("non-final beat with an error status");

  // Pointers stay inside the ring.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rp_q <= PtrMax) && (wp_q <= PtrMax) && (pp_q <= PtrMax))
    else $error("ring pointer beyond DEPTH-1");

  // A new result is formed only when the output register can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.emit |-> slot_free)
    else $error("result beat overwrote an untaken beat");

endmodule

// ===== test/tb_byte_ring_fifo_reserve_commit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_byte_ring_fifo_reserve_commit: self-checking bench for the byte ring FIFO
// Drives reserve/put/commit/read/advance/close commands over a valid/ready
// channel and checks every result beat against an in-bench model of the
// ring. A directed opening and closing frame the random traffic. The random
// traffic runs in three idle profiles, with a long result-side hold-off and
// with sender pauses that let all results drain.
// ----------------------------------------------------------------------------
module tb_byte_ring_fifo_reserve_commit;

  // Sizes mirrored from the package.
  localparam int unsigned CmdW    = brfrc_pkg::CmdW;
  localparam int unsigned LenW    = brfrc_pkg::LenW;
  localparam int unsigned ByteW   = brfrc_pkg::ByteW;
  localparam int unsigned StatusW = brfrc_pkg::StatusW;
  localparam int unsigned Depth   = brfrc_pkg::DepthDef;
  localparam int unsigned MaxRead = brfrc_pkg::MaxReadDef;

  // Command codes that the block ignores.
  localparam logic [CmdW-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CmdW-1:0] CMD_SPARE7 = 3'd7;

  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = 32;
  localparam int unsigned PHASE_ITEMS    = 78;

  // One result beat as seen on the output channel.
  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [LenW-1:0]    count;
    logic [ByteW-1:0]   data;
    logic               last;
  } ring_beat_t;

  // Model of the ring plus the queue of result beats still owed by the block.
  class byte_ring_scoreboard;
    logic [ByteW-1:0] store [Depth];
    bit               written [Depth];
    int unsigned      rd_ptr, wr_ptr, fill_ptr, fill_left;
    bit               fill_open, closed;
    ring_beat_t       awaited [$];
    int unsigned      failures, beats_checked;
    int unsigned      cmd_seen [8];

    // Bytes published between the read and write pointers.
    function int unsigned stored();
      return (wr_ptr + Depth - rd_ptr) % Depth;
    endfunction

    // Free space that a reservation may claim.
    function int unsigned room();
      int unsigned gap;
      gap = (rd_ptr + Depth - wr_ptr) % Depth;
      return (gap == 0) ? Depth - 1 : gap - 1;
    endfunction

    // False when a read of len would deliver a byte that was never written.
    function bit read_defined(int unsigned len);
      if (len == 0 || len > MaxRead || len > stored()) return 1'b1;
      for (int unsigned i = 0; i < len; i++) begin
        if (!written[(rd_ptr + i) % Depth]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void add_beat(logic [StatusW-1:0] st, logic [LenW-1:0] cnt,
                           logic [ByteW-1:0] b, logic lst);
      ring_beat_t bt;
      bt.status = st;
      bt.count  = cnt;
      bt.data   = b;
      bt.last   = lst;
      awaited.push_back(bt);
    endfunction

    // Apply one accepted command and queue the beats it must produce.
    function void accept_cmd(logic [CmdW-1:0] cmd, logic [LenW-1:0] len,
                             logic [ByteW-1:0] din);
      cmd_seen[cmd]++;
      case (cmd)
        brfrc_pkg::CMD_RESERVE: begin
          if (closed) add_beat(brfrc_pkg::STAT_CLOSED, '0, '0, 1'b1);
          else if (fill_open) add_beat(brfrc_pkg::STAT_PENDING, '0, '0, 1'b1);
          else if (room() < len) add_beat(brfrc_pkg::STAT_BLOCK, '0, '0, 1'b1);
          else begin
            fill_ptr  = wr_ptr;
            fill_left = len;
            fill_open = 1'b1;
            add_beat(brfrc_pkg::STAT_OK, len, '0, 1'b1);
          end
        end
        brfrc_pkg::CMD_PUT: begin
          if (closed) add_beat(brfrc_pkg::STAT_CLOSED, '0, '0, 1'b1);
          else if (fill_left == 0) add_beat(brfrc_pkg::STAT_MISMATCH, '0, '0, 1'b1);
          else begin
            store[fill_ptr]   = din;
            written[fill_ptr] = 1'b1;
            fill_ptr  = (fill_ptr + 1) % Depth;
            fill_left--;
            add_beat(brfrc_pkg::STAT_OK, LenW'(1), '0, 1'b1);
          end
        end
        brfrc_pkg::CMD_COMMIT: begin
          if (closed) add_beat(brfrc_pkg::STAT_CLOSED, '0, '0, 1'b1);
          else if (!fill_open || fill_left != 0)
            add_beat(brfrc_pkg::STAT_MISMATCH, '0, '0, 1'b1);
          else begin
            wr_ptr    = fill_ptr;
            fill_open = 1'b0;
            add_beat(brfrc_pkg::STAT_OK, '0, '0, 1'b1);
          end
        end
        brfrc_pkg::CMD_READ: begin
          if (len > MaxRead) add_beat(brfrc_pkg::STAT_TOO_LONG, '0, '0, 1'b1);
          else if (stored() < len)
            add_beat(closed ? brfrc_pkg::STAT_CLOSED : brfrc_pkg::STAT_BLOCK,
                     '0, '0, 1'b1);
          else if (len == 0) add_beat(brfrc_pkg::STAT_OK, '0, '0, 1'b1);
          else begin
            // All or nothing: one beat per byte, last flag on the final one.
            for (int unsigned i = 0; i < len; i++) begin
              add_beat(brfrc_pkg::STAT_OK, len, store[rd_ptr], (i + 1 == len));
              rd_ptr = (rd_ptr + 1) % Depth;
            end
          end
        end
        brfrc_pkg::CMD_ADVANCE: begin
          rd_ptr = (rd_ptr + len) % Depth;
          add_beat(brfrc_pkg::STAT_OK, len, '0, 1'b1);
        end
        brfrc_pkg::CMD_CLOSE: begin
          closed = 1'b1;
          add_beat(brfrc_pkg::STAT_OK, '0, '0, 1'b1);
        end
        default: begin
          // Unused codes leave the ring alone and produce nothing.
        end
      endcase
    endfunction

    // Compare one accepted result beat with the oldest outstanding one.
    function void check_beat(ring_beat_t got);
      ring_beat_t want;
      if (awaited.size() == 0) begin
        $error("unexpected result beat: status %0d count %0d data_out 0x%02h last %0b",
               got.status, got.count, got.data, got.last);
        failures++;
        return;
      end
      want = awaited.pop_front();
      beats_checked++;
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        failures++;
      end
      if (got.count !== want.count) begin
        $error("count: expected %0d, got %0d", want.count, got.count);
        failures++;
      end
      if (got.data !== want.data) begin
        $error("data_out: expected 0x%02h, got 0x%02h", want.data, got.data);
        failures++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        failures++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [CmdW-1:0]    cmd_i;
  logic [LenW-1:0]    length_i;
  logic [ByteW-1:0]   data_in_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [StatusW-1:0] status_o;
  logic [LenW-1:0]    count_o;
  logic [ByteW-1:0]   data_out_o;
  logic               last_o;

  byte_ring_scoreboard sb = new;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned holds_asked;
  int unsigned cmds_sent;

  byte_ring_fifo_reserve_commit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .length_i    (length_i),
    .data_in_i   (data_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .count_o     (count_o),
    .data_out_o  (data_out_o),
    .last_o      (last_o)
  );

  // 100 MHz clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: random back-pressure, plus a long hold-off when asked.
  initial begin : result_sink
    int unsigned holds_done;
    holds_done  = 0;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (holds_done != holds_asked) begin
        holds_done++;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Every beat taken on the output channel is checked in order.
  always @(posedge clk_i) begin : result_monitor
    ring_beat_t got;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      got.status = status_o;
      got.count  = count_o;
      got.data   = data_out_o;
      got.last   = last_o;
      sb.check_beat(got);
    end
  end

  // Ends the run when neither channel moves a beat for too long.
  initial begin : watchdog
    int unsigned stuck_cycles;
    stuck_cycles = 0;
    while (stuck_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o === 1'b1) || (out_valid_o === 1'b1 && out_ready_i))
        stuck_cycles = 0;
      else
        stuck_cycles++;
    end
    $display("byte_ring_fifo_reserve_commit test failed");
    $finish;
  end

  // Offer one command and hold it until accepted. Reads that would touch
  // never-written bytes are turned into over-long reads instead.
  task automatic issue(input logic [CmdW-1:0] c, input int unsigned len,
                       input int unsigned d);
    logic [LenW-1:0]  use_len;
    logic [ByteW-1:0] use_data;
    use_len  = LenW'(len);
    use_data = ByteW'(d);
    if (c == brfrc_pkg::CMD_READ && !sb.read_defined(use_len))
      use_len = LenW'(MaxRead + 1);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= c;
    length_i   <= use_len;
    data_in_i  <= use_data;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sb.accept_cmd(c, use_len, use_data);
    if (c != CMD_SPARE6 && c != CMD_SPARE7) cmds_sent++;
  endtask

  // Sender pause until every owed beat has arrived.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.awaited.size() != 0);
  endtask

  // Malformed or out-of-range commands.
  task automatic noise_item();
    int unsigned pick, len;
    pick = $urandom_range(4);
    case (pick)
      0: begin
        if (sb.fill_open) len = $urandom_range(1023);
        else begin
          len = sb.room() + 1 + $urandom_range(8);
          if (len > 1023) len = (sb.room() == 1023) ? $urandom_range(4) : 1023;
        end
        issue(brfrc_pkg::CMD_RESERVE, len, $urandom_range(255));
      end
      1: issue(brfrc_pkg::CMD_PUT, $urandom_range(1023), $urandom_range(255));
      2: issue(brfrc_pkg::CMD_COMMIT, $urandom_range(1023), $urandom_range(255));
      3: issue(brfrc_pkg::CMD_READ, $urandom_range(1023), $urandom_range(255));
      default: issue($urandom_range(1) ? CMD_SPARE7 : CMD_SPARE6,
                     $urandom_range(1023), $urandom_range(255));
    endcase
  endtask

  // Mostly well-formed reserve/fill/commit and read traffic with noise mixed in.
  task automatic random_traffic(input int unsigned n_items);
    int unsigned target, pick, len, have, r0;
    target = cmds_sent + n_items;
    while (cmds_sent < target) begin
      pick = $urandom_range(99);
      if (sb.fill_open && sb.fill_left != 0) begin
        if (pick < 92) issue(brfrc_pkg::CMD_PUT, $urandom_range(1023), $urandom_range(255));
        else noise_item();
      end else if (sb.fill_open) begin
        if (pick < 90) issue(brfrc_pkg::CMD_COMMIT, 0, $urandom_range(255));
        else noise_item();
      end else begin
        have = sb.stored();
        if (pick < 35) begin
          len = ($urandom_range(7) == 0) ? $urandom_range(MaxRead) : $urandom_range(12);
          if ($urandom_range(19) == 0) len = (sb.room() < 1020) ? sb.room() + 1 : 2;
          issue(brfrc_pkg::CMD_RESERVE, len, $urandom_range(255));
        end else if (pick < 75) begin
          len = (have < MaxRead) ? have : MaxRead;
          if (len == MaxRead && $urandom_range(2) == 0) len = MaxRead;
          else len = $urandom_range(len);
          if ($urandom_range(9) == 0) len = have + 1 + $urandom_range(4);
          if (len > 1023) len = 1023;
          issue(brfrc_pkg::CMD_READ, len, $urandom_range(255));
        end else if (pick < 85) begin
          issue(brfrc_pkg::CMD_ADVANCE, $urandom_range((have < 8) ? have : 8),
                $urandom_range(255));
        end else if (pick < 90) begin
          // Jump the reader anywhere, try a read there, then jump back.
          r0 = sb.rd_ptr;
          issue(brfrc_pkg::CMD_ADVANCE, $urandom_range(1023), $urandom_range(255));
          issue(brfrc_pkg::CMD_READ, $urandom_range(MaxRead), $urandom_range(255));
          issue(brfrc_pkg::CMD_ADVANCE, (r0 + Depth - sb.rd_ptr) % Depth,
                $urandom_range(255));
        end else begin
          noise_item();
        end
      end
    end
  endtask

  initial begin : stimulus
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    cmd_i       = brfrc_pkg::CMD_RESERVE;
    length_i    = '0;
    data_in_i   = '0;
    tx_idle_pct = 16;
    rx_idle_pct = 75;
    holds_asked = 0;
    cmds_sent   = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty ring: zero-length read, blocked read, over-long read, stray
    // put and commit with no reservation, and the ignored codes.
    issue(brfrc_pkg::CMD_READ, 0, 8'h00);
    issue(brfrc_pkg::CMD_READ, 1, 8'h00);
    issue(brfrc_pkg::CMD_READ, MaxRead + 1, 8'h00);
    issue(brfrc_pkg::CMD_PUT, 0, 8'h3C);
    issue(brfrc_pkg::CMD_COMMIT, 0, 8'h00);
    issue(CMD_SPARE6, 1023, 8'hFF);
    issue(CMD_SPARE7, 0, 8'h00);

    // Move the reader four ahead so that exactly three bytes are free, then
    // probe the free-space edge, unfilled commit, overrun, empty reservation,
    // double reservation, and rewind the reader with a near-DEPTH advance.
    issue(brfrc_pkg::CMD_ADVANCE, 4, 8'h00);
    issue(brfrc_pkg::CMD_RESERVE, 4, 8'h00);
    issue(brfrc_pkg::CMD_RESERVE, 3, 8'h00);
    issue(brfrc_pkg::CMD_COMMIT, 0, 8'h00);
    issue(brfrc_pkg::CMD_PUT, 0, 8'h00);
    issue(brfrc_pkg::CMD_PUT, 0, 8'hFF);
    issue(brfrc_pkg::CMD_PUT, 0, 8'hA5);
    issue(brfrc_pkg::CMD_PUT, 0, 8'h11);
    issue(brfrc_pkg::CMD_COMMIT, 0, 8'h00);
    issue(brfrc_pkg::CMD_RESERVE, 1, 8'h00);
    issue(brfrc_pkg::CMD_RESERVE, 0, 8'h00);
    issue(brfrc_pkg::CMD_RESERVE, 2, 8'h00);
    issue(brfrc_pkg::CMD_COMMIT, 0, 8'h00);
    issue(brfrc_pkg::CMD_ADVANCE, Depth - 4, 8'h00);
    issue(brfrc_pkg::CMD_READ, 3, 8'h00);

    random_traffic(PHASE_ITEMS);
    wait_for_results();

    tx_idle_pct = 75;
    rx_idle_pct = 16;
    random_traffic(PHASE_ITEMS);
    wait_for_results();

    // No idling; the result side stalls for a long stretch at the start.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    holds_asked++;
    random_traffic(PHASE_ITEMS);

    // Finish any open reservation, leave two known bytes, then close.
    while (sb.fill_open) begin
      if (sb.fill_left != 0) issue(brfrc_pkg::CMD_PUT, 0, $urandom_range(255));
      else issue(brfrc_pkg::CMD_COMMIT, 0, 8'h00);
    end
    issue(brfrc_pkg::CMD_ADVANCE, sb.stored(), 8'h00);
    issue(brfrc_pkg::CMD_RESERVE, 2, 8'h00);
    issue(brfrc_pkg::CMD_PUT, 0, 8'h5A);
    issue(brfrc_pkg::CMD_PUT, 0, 8'hC3);
    issue(brfrc_pkg::CMD_COMMIT, 0, 8'h00);
    issue(brfrc_pkg::CMD_CLOSE, 0, 8'h00);
    issue(brfrc_pkg::CMD_RESERVE, 1, 8'h00);
    issue(brfrc_pkg::CMD_PUT, 0, 8'h77);
    issue(brfrc_pkg::CMD_COMMIT, 0, 8'h00);
    issue(brfrc_pkg::CMD_READ, 1, 8'h00);
    issue(brfrc_pkg::CMD_READ, 2, 8'h00);
    issue(brfrc_pkg::CMD_ADVANCE, 0, 8'h00);

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d commands: %0d reserve, %0d put, %0d commit, %0d read,",
             cmds_sent, sb.cmd_seen[brfrc_pkg::CMD_RESERVE],
             sb.cmd_seen[brfrc_pkg::CMD_PUT], sb.cmd_seen[brfrc_pkg::CMD_COMMIT],
             sb.cmd_seen[brfrc_pkg::CMD_READ]);
    $display("%0d advance, %0d close, %0d unused codes; %0d beats checked, %0d mismatches.",
             sb.cmd_seen[brfrc_pkg::CMD_ADVANCE], sb.cmd_seen[brfrc_pkg::CMD_CLOSE],
             sb.cmd_seen[CMD_SPARE6] + sb.cmd_seen[CMD_SPARE7],
             sb.beats_checked, sb.failures);
    if (sb.failures == 0)
      $display("byte_ring_fifo_reserve_commit test passed");
    else
      $display("byte_ring_fifo_reserve_commit test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/brfrc_pkg.sv
sv/brfrc_mem.sv
sv/brfrc_alu.sv
sv/brfrc_ctrl.sv
sv/byte_ring_fifo_reserve_commit.sv
test/tb_byte_ring_fifo_reserve_commit.sv
